// ===== src/kle_pkg.sv =====
// Shared types, constants and the key translation function for the keycode line editor.
// Depends on nothing; used by every module of the block.
package kle_pkg;

    localparam int LINE_MAX = 64;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int LEN_W    = ADDR_W + 1;

    // Key codes
    localparam logic [7:0] KC_ESC       = 8'd1;
    localparam logic [7:0] KC_ONE       = 8'd2;
    localparam logic [7:0] KC_ZERO      = 8'd11;
    localparam logic [7:0] KC_BACKSPACE = 8'd14;
    localparam logic [7:0] KC_Q         = 8'd16;
    localparam logic [7:0] KC_P         = 8'd25;
    localparam logic [7:0] KC_ENTER     = 8'd28;
    localparam logic [7:0] KC_A         = 8'd30;
    localparam logic [7:0] KC_L         = 8'd38;
    localparam logic [7:0] KC_Z         = 8'd44;
    localparam logic [7:0] KC_DOT       = 8'd52;
    localparam logic [7:0] KC_SPACE     = 8'd57;

    // Result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_BELL   = 2'd3;

    // Symbol pairs, unshifted then shifted; first character in the top byte
    localparam int TOP_LEN   = 20;
    localparam int HOME_LEN  = 18;
    localparam int LOW_LEN   = 18;
    localparam int DIGIT_LEN = 20;
    localparam logic [8*TOP_LEN-1:0]   TOP_ROW   = "qQwWeErRtTyYuUiIoOpP";
    localparam logic [8*HOME_LEN-1:0]  HOME_ROW  = "aAsSdDfFgGhHjJkKlL";
    localparam logic [8*LOW_LEN-1:0]   LOW_ROW   = "zZxXcCvVbBnNmM,;.:";
    localparam logic [8*DIGIT_LEN-1:0] DIGIT_ROW = "1!2\"3#4$5%6&7/8(9)0=";

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_DRAIN = 3'b100
    } kle_state_t;

    // What the captured key asks for
    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_IGNORE,
        CLS_BELL,
        CLS_ESC,
        CLS_ENTER,
        CLS_BKSP
    } kle_cls_t;

    typedef struct packed {
        logic       capture;
        logic       append;
        logic       backspace;
        logic       clear_line;
        logic       load_result;
        logic [1:0] result_kind;
        logic       rd_start;
        logic       drain_step;
    } kle_cmd_t;

    typedef struct packed {
        kle_cls_t key_cls;
        logic     line_empty;
        logic     line_full;
        logic     drain_last;
        logic     out_free;
    } kle_status_t;

    // Printable character for a key, zero if the key has none
    function automatic logic [7:0] translate(input logic [7:0] code, input logic shift);
        logic [7:0] ch;
        logic [4:0] idx;
        ch  = '0;
        idx = '0;
        if (code >= KC_Q && code <= KC_P) begin
            idx = {4'(code - KC_Q), shift};
            ch  = TOP_ROW[(TOP_LEN - 1 - int'(idx)) * 8 +: 8];
        end else if (code >= KC_A && code <= KC_L) begin
            idx = {4'(code - KC_A), shift};
            ch  = HOME_ROW[(HOME_LEN - 1 - int'(idx)) * 8 +: 8];
        end else if (code >= KC_Z && code <= KC_DOT) begin
            idx = {4'(code - KC_Z), shift};
            ch  = LOW_ROW[(LOW_LEN - 1 - int'(idx)) * 8 +: 8];
        end else if (code >= KC_ONE && code <= KC_ZERO) begin
            idx = {4'(code - KC_ONE), shift};
            ch  = DIGIT_ROW[(DIGIT_LEN - 1 - int'(idx)) * 8 +: 8];
        end else if (code == KC_SPACE) begin
            ch = 8'h20;
        end
        return ch;
    endfunction

endpackage

// ===== src/kle_ctrl.sv =====
// Controller state machine for the keycode line editor: sequences capture, decode and drain.
// Depends on kle_pkg; drives kle_dp through kle_cmd_t and reads kle_status_t.
module kle_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  kle_pkg::kle_status_t sts,
    output kle_pkg::kle_cmd_t    cmd
);

    kle_pkg::kle_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kle_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == kle_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            kle_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = kle_pkg::ST_EXEC;
                end
            end
            kle_pkg::ST_EXEC: begin
                case (sts.key_cls)
                    kle_pkg::CLS_PRINT: begin
                        if (!sts.line_full) begin
                            cmd.append = 1'b1;
                            state_next = kle_pkg::ST_IDLE;
                        end else if (sts.out_free) begin
                            cmd.load_result = 1'b1;
                            cmd.result_kind = kle_pkg::KIND_BELL;
                            state_next      = kle_pkg::ST_IDLE;
                        end
                    end
                    kle_pkg::CLS_IGNORE: begin
                        state_next = kle_pkg::ST_IDLE;
                    end
                    kle_pkg::CLS_ESC: begin
                        if (sts.out_free) begin
                            cmd.load_result = 1'b1;
                            cmd.result_kind = kle_pkg::KIND_CANCEL;
                            cmd.clear_line  = 1'b1;
                            state_next      = kle_pkg::ST_IDLE;
                        end
                    end
                    kle_pkg::CLS_ENTER: begin
                        if (!sts.line_empty) begin
                            cmd.rd_start = 1'b1;
                            state_next   = kle_pkg::ST_DRAIN;
                        end else if (sts.out_free) begin
                            cmd.load_result = 1'b1;
                            cmd.result_kind = kle_pkg::KIND_EMPTY;
                            state_next      = kle_pkg::ST_IDLE;
                        end
                    end
                    kle_pkg::CLS_BKSP: begin
                        cmd.backspace = 1'b1;
                        state_next    = kle_pkg::ST_IDLE;
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.load_result = 1'b1;
                            cmd.result_kind = kle_pkg::KIND_BELL;
                            state_next      = kle_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            kle_pkg::ST_DRAIN: begin
                if (sts.out_free) begin
                    cmd.drain_step = 1'b1;
                    if (sts.drain_last) begin
                        cmd.clear_line = 1'b1;
                        state_next     = kle_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = kle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/kle_dp.sv =====
// Datapath of the keycode line editor: key register, key decode, line store, length, output register.
// Depends on kle_pkg; commanded by kle_ctrl.
module kle_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast,
    input  kle_pkg::kle_cmd_t    cmd,
    output kle_pkg::kle_status_t sts
);

    localparam int AW = kle_pkg::ADDR_W;
    localparam int LW = kle_pkg::LEN_W;

    logic [7:0]    code_reg;
    logic          shift_reg;
    logic          ctrl_reg;
    logic [LW-1:0] len_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    line_mem [kle_pkg::LINE_MAX];

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic [1:0]    out_kind_reg;
    logic          out_last_reg;

    logic [7:0]    key_char;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    kle_pkg::kle_cls_t key_cls;

    // Key register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg  <= s_tdata;
            shift_reg <= s_tuser[0];
            ctrl_reg  <= s_tuser[1];
        end
    end

    // Control suppresses translation, so such keys fall to the command decode
    assign key_char = ctrl_reg ? 8'd0 : kle_pkg::translate(code_reg, shift_reg);

    always_comb begin
        if (key_char != 8'd0) begin
            key_cls = kle_pkg::CLS_PRINT;
        end else if (ctrl_reg && !shift_reg && code_reg == kle_pkg::KC_L) begin
            key_cls = kle_pkg::CLS_IGNORE;
        end else if (ctrl_reg || shift_reg) begin
            key_cls = kle_pkg::CLS_BELL;
        end else begin
            unique case (code_reg)
                kle_pkg::KC_ESC:       key_cls = kle_pkg::CLS_ESC;
                kle_pkg::KC_ENTER:     key_cls = kle_pkg::CLS_ENTER;
                kle_pkg::KC_BACKSPACE: key_cls = kle_pkg::CLS_BKSP;
                default:               key_cls = kle_pkg::CLS_BELL;
            endcase
        end
    end

    // Line length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd.clear_line) begin
            len_reg <= '0;
        end else if (cmd.append) begin
            len_reg <= len_reg + LW'(1);
        end else if (cmd.backspace && len_reg != '0) begin
            len_reg <= len_reg - LW'(1);
        end
    end

    // Drain index; points at the character held in rdata_reg
    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            idx_reg <= '0;
        end else if (cmd.drain_step) begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Prefetch the next character each time one moves to the output
    assign rd_en   = cmd.rd_start | cmd.drain_step;
    assign rd_addr = cmd.rd_start ? '0 : idx_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            line_mem[len_reg[AW-1:0]] <= key_char;
        end
        if (rd_en) begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_result || cmd.drain_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_kind_reg <= cmd.result_kind;
            out_char_reg <= 8'd0;
            out_last_reg <= 1'b1;
        end else if (cmd.drain_step) begin
            out_kind_reg <= kle_pkg::KIND_CHAR;
            out_char_reg <= rdata_reg;
            out_last_reg <= sts.drain_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign sts.key_cls    = key_cls;
    assign sts.line_empty = (len_reg == '0);
    assign sts.line_full  = (len_reg == LW'(kle_pkg::LINE_MAX));
    assign sts.drain_last = (({1'b0, idx_reg} + LW'(1)) == len_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

// ===== src/keycode_line_editor_unit.sv =====
// Keycode line editor top level: kle_ctrl state machine plus kle_dp datapath (uses kle_pkg).
// Sequence: a key is captured into the key register on its transfer and decoded in the exec
//   state; a single result, or each character of a line, is loaded into the output register.
// Throughput: a new key is taken only in idle; result loads and the drain wait while the output is full;
//   Enter drains one character per cycle out of the line store's single read port while m_tready holds.
// Reset (aresetn low, synchronous): line length, state machine and output valid cleared;
//   the line store is not cleared, entries are only read after being written.
module keycode_line_editor_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // Key events
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] keycode
    input  logic [1:0] s_tuser,   // [0] shift_held, [1] control_held
    // Results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] character
    output logic [1:0] m_tuser,   // [1:0] result_kind
    output logic       m_tlast    // last_of_line
);

    // Controller to datapath commands, datapath to controller status
    kle_pkg::kle_cmd_t    cmd;
    kle_pkg::kle_status_t sts;

    // Sequencer: idle -> exec (decode, append, backspace, single results) -> drain (Enter)
    kle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Key decode, line store, length counter and output register.
    // The output register frees the key side: a new key transfer is taken
    // while a result waits for m_tready.
    kle_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== src/kle_checker.sv =====
// Port-level checks for keycode_line_editor_unit, bound to the top level.
// Depends on kle_pkg for the result kind codes.
module kle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // Stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Only line characters carry a character
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != kle_pkg::KIND_CHAR |-> m_tdata == 8'd0)
        else $error("non-character result with nonzero data");

    // Status results are single and therefore last
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != kle_pkg::KIND_CHAR |-> m_tlast)
        else $error("status result without last");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // No key taken while a line is draining mid-way
    a_no_accept_mid_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == kle_pkg::KIND_CHAR && !m_tlast |-> !s_tready)
        else $error("key accepted during line drain");

endmodule

bind keycode_line_editor_unit kle_checker u_kle_checker (.*);
